FILE: sv/spi_pkg.sv
// Shared types and widths for the segment pair intersection pipeline.
`timescale 1ns / 1ps
package spi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int XPROD_BITS = PROD_BITS + 1;
  localparam int DEN_BITS   = 2 * COORD_BITS + 1;
  localparam int QUO_BITS   = COORD_BITS + FRAC_BITS;
  localparam int ABS_BITS   = DEN_BITS + COORD_BITS;
  localparam int MAG_BITS   = DEN_BITS + QUO_BITS;
  localparam int SCALE_BITS = DEN_BITS + 1 + DIFF_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_BITS-1:0]   out_coord_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } spi_in_t;

  typedef struct packed {
    logic       segments_touch;
    logic       point_valid;
    out_coord_t cross_x;
    out_coord_t cross_y;
  } spi_out_t;

  typedef struct packed {
    logic   touch;
    logic   pvalid;
    logic   neg_x;
    logic   neg_y;
    coord_t base_x;
    coord_t base_y;
  } div_side_t;

endpackage

FILE: sv/spi_geom.sv
// Orientation tests, touch decision and scaled crossing numerators.
`timescale 1ns / 1ps
module spi_geom (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  spi_pkg::spi_in_t                  in_i,
  output logic                              out_valid_o,
  output spi_pkg::div_side_t                side_o,
  output logic [spi_pkg::MAG_BITS-1:0]      mag_x_o,
  output logic [spi_pkg::MAG_BITS-1:0]      mag_y_o,
  output logic [spi_pkg::DEN_BITS-1:0]      den_o
);
  import spi_pkg::*;

  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [XPROD_BITS-1:0] xprod_t;
  typedef logic signed [SCALE_BITS-1:0] scale_t;

  logic [5:0] v_q;

  diff_t  ox_q, oy_q, e1x_q, e1y_q, f1x_q, f1y_q, dax_q, day_q, dbx1_q, dby1_q;
  logic   box_a0_q, box_a1_q, box_b0_q, box_b1_q;
  coord_t bx1_q, by1_q;

  diff_t  ox_d, oy_d, e1x_d, e1y_d, f1x_d, f1y_d, dax_d, day_d, dbx_d, dby_d;
  logic   box_a0_d, box_a1_d, box_b0_d, box_b1_d;
  coord_t bminx, bmaxx, bminy, bmaxy, aminx, amaxx, aminy, amaxy;

  prod_t  p1a_q, p1b_q, p2a_q, p2b_q, p3a_q, p3b_q, p4a_q, p4b_q, pda_q, pdb_q;
  logic   box_a0_2q, box_a1_2q, box_b0_2q, box_b1_2q;
  diff_t  dbx2_q, dby2_q;
  coord_t bx2_q, by2_q;

  xprod_t s1, s2, s3, s4, dn;
  logic   n1, n2, n3, n4, z1, z2, z3, z4, ps1, ps2, ps3, ps4;
  logic   touch_d;
  logic   touch3_q;
  xprod_t den3_q, num3_q;
  diff_t  dbx3_q, dby3_q;
  coord_t bx3_q, by3_q;

  xprod_t den_n, num_n;
  logic   pvalid_d;
  logic   touch4_q, pvalid4_q;
  logic [DEN_BITS-1:0] den4_q, num4_q;
  diff_t  dbx4_q, dby4_q;
  coord_t bx4_q, by4_q;

  logic   touch5_q, pvalid5_q;
  scale_t px5_q, py5_q;
  logic [DEN_BITS-1:0] den5_q;
  coord_t bx5_q, by5_q;

  scale_t ax_abs, ay_abs;
  div_side_t side6_q;
  logic [MAG_BITS-1:0] mx6_q, my6_q;
  logic [DEN_BITS-1:0] den6_q;

  // stage 1: differences and bounding boxes
  assign ox_d  = DIFF_BITS'(in_i.a_start_x) - DIFF_BITS'(in_i.b_start_x);
  assign oy_d  = DIFF_BITS'(in_i.a_start_y) - DIFF_BITS'(in_i.b_start_y);
  assign e1x_d = DIFF_BITS'(in_i.a_end_x)   - DIFF_BITS'(in_i.b_start_x);
  assign e1y_d = DIFF_BITS'(in_i.a_end_y)   - DIFF_BITS'(in_i.b_start_y);
  assign f1x_d = DIFF_BITS'(in_i.b_end_x)   - DIFF_BITS'(in_i.a_start_x);
  assign f1y_d = DIFF_BITS'(in_i.b_end_y)   - DIFF_BITS'(in_i.a_start_y);
  assign dax_d = DIFF_BITS'(in_i.a_end_x)   - DIFF_BITS'(in_i.a_start_x);
  assign day_d = DIFF_BITS'(in_i.a_end_y)   - DIFF_BITS'(in_i.a_start_y);
  assign dbx_d = DIFF_BITS'(in_i.b_end_x)   - DIFF_BITS'(in_i.b_start_x);
  assign dby_d = DIFF_BITS'(in_i.b_end_y)   - DIFF_BITS'(in_i.b_start_y);

  assign bminx = (in_i.b_start_x < in_i.b_end_x) ? in_i.b_start_x : in_i.b_end_x;
  assign bmaxx = (in_i.b_start_x < in_i.b_end_x) ? in_i.b_end_x : in_i.b_start_x;
  assign bminy = (in_i.b_start_y < in_i.b_end_y) ? in_i.b_start_y : in_i.b_end_y;
  assign bmaxy = (in_i.b_start_y < in_i.b_end_y) ? in_i.b_end_y : in_i.b_start_y;
  assign aminx = (in_i.a_start_x < in_i.a_end_x) ? in_i.a_start_x : in_i.a_end_x;
  assign amaxx = (in_i.a_start_x < in_i.a_end_x) ? in_i.a_end_x : in_i.a_start_x;
  assign aminy = (in_i.a_start_y < in_i.a_end_y) ? in_i.a_start_y : in_i.a_end_y;
  assign amaxy = (in_i.a_start_y < in_i.a_end_y) ? in_i.a_end_y : in_i.a_start_y;

  assign box_a0_d = (bminx <= in_i.a_start_x) && (in_i.a_start_x <= bmaxx) &&
                    (bminy <= in_i.a_start_y) && (in_i.a_start_y <= bmaxy);
  assign box_a1_d = (bminx <= in_i.a_end_x) && (in_i.a_end_x <= bmaxx) &&
                    (bminy <= in_i.a_end_y) && (in_i.a_end_y <= bmaxy);
  assign box_b0_d = (aminx <= in_i.b_start_x) && (in_i.b_start_x <= amaxx) &&
                    (aminy <= in_i.b_start_y) && (in_i.b_start_y <= amaxy);
  assign box_b1_d = (aminx <= in_i.b_end_x) && (in_i.b_end_x <= amaxx) &&
                    (aminy <= in_i.b_end_y) && (in_i.b_end_y <= amaxy);

  // stage 3: cross products and touch decision
  assign s1 = XPROD_BITS'(p1a_q) - XPROD_BITS'(p1b_q);
  assign s2 = XPROD_BITS'(p2a_q) - XPROD_BITS'(p2b_q);
  assign s3 = XPROD_BITS'(p3a_q) - XPROD_BITS'(p3b_q);
  assign s4 = XPROD_BITS'(p4a_q) - XPROD_BITS'(p4b_q);
  assign dn = XPROD_BITS'(pda_q) - XPROD_BITS'(pdb_q);

  assign n1 = s1[XPROD_BITS-1];
  assign n2 = s2[XPROD_BITS-1];
  assign n3 = s3[XPROD_BITS-1];
  assign n4 = s4[XPROD_BITS-1];
  assign z1 = (s1 == '0);
  assign z2 = (s2 == '0);
  assign z3 = (s3 == '0);
  assign z4 = (s4 == '0);
  assign ps1 = !n1 && !z1;
  assign ps2 = !n2 && !z2;
  assign ps3 = !n3 && !z3;
  assign ps4 = !n4 && !z4;

  assign touch_d = (((n1 && ps2) || (ps1 && n2)) && ((n3 && ps4) || (ps3 && n4)))
                || (z1 && box_a0_2q) || (z2 && box_a1_2q)
                || (z3 && box_b0_2q) || (z4 && box_b1_2q);

  // stage 4: normalize denominator sign, range check on t
  assign den_n = den3_q[XPROD_BITS-1] ? -den3_q : den3_q;
  assign num_n = den3_q[XPROD_BITS-1] ? -num3_q : num3_q;
  assign pvalid_d = touch3_q && (den_n != '0) && !num_n[XPROD_BITS-1] && (num_n <= den_n);

  // stage 6: magnitudes, scaled by the fraction bits
  assign ax_abs = px5_q[SCALE_BITS-1] ? -px5_q : px5_q;
  assign ay_abs = py5_q[SCALE_BITS-1] ? -py5_q : py5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      e1x_q    <= e1x_d;
      e1y_q    <= e1y_d;
      f1x_q    <= f1x_d;
      f1y_q    <= f1y_d;
      dax_q    <= dax_d;
      day_q    <= day_d;
      dbx1_q   <= dbx_d;
      dby1_q   <= dby_d;
      box_a0_q <= box_a0_d;
      box_a1_q <= box_a1_d;
      box_b0_q <= box_b0_d;
      box_b1_q <= box_b1_d;
      bx1_q    <= in_i.b_start_x;
      by1_q    <= in_i.b_start_y;

      p1a_q     <= PROD_BITS'(ox_q)   * PROD_BITS'(dby1_q);
      p1b_q     <= PROD_BITS'(dbx1_q) * PROD_BITS'(oy_q);
      p2a_q     <= PROD_BITS'(e1x_q)  * PROD_BITS'(dby1_q);
      p2b_q     <= PROD_BITS'(dbx1_q) * PROD_BITS'(e1y_q);
      p3a_q     <= PROD_BITS'(oy_q)   * PROD_BITS'(dax_q);
      p3b_q     <= PROD_BITS'(ox_q)   * PROD_BITS'(day_q);
      p4a_q     <= PROD_BITS'(f1x_q)  * PROD_BITS'(day_q);
      p4b_q     <= PROD_BITS'(dax_q)  * PROD_BITS'(f1y_q);
      pda_q     <= PROD_BITS'(dby1_q) * PROD_BITS'(dax_q);
      pdb_q     <= PROD_BITS'(dbx1_q) * PROD_BITS'(day_q);
      box_a0_2q <= box_a0_q;
      box_a1_2q <= box_a1_q;
      box_b0_2q <= box_b0_q;
      box_b1_2q <= box_b1_q;
      dbx2_q    <= dbx1_q;
      dby2_q    <= dby1_q;
      bx2_q     <= bx1_q;
      by2_q     <= by1_q;

      touch3_q <= touch_d;
      den3_q   <= dn;
      num3_q   <= s3;
      dbx3_q   <= dbx2_q;
      dby3_q   <= dby2_q;
      bx3_q    <= bx2_q;
      by3_q    <= by2_q;

      touch4_q  <= touch3_q;
      pvalid4_q <= pvalid_d;
      den4_q    <= den_n[DEN_BITS-1:0];
      num4_q    <= num_n[DEN_BITS-1:0];
      dbx4_q    <= dbx3_q;
      dby4_q    <= dby3_q;
      bx4_q     <= bx3_q;
      by4_q     <= by3_q;

      touch5_q  <= touch4_q;
      pvalid5_q <= pvalid4_q;
      px5_q     <= SCALE_BITS'(signed'({1'b0, num4_q})) * SCALE_BITS'(dbx4_q);
      py5_q     <= SCALE_BITS'(signed'({1'b0, num4_q})) * SCALE_BITS'(dby4_q);
      den5_q    <= den4_q;
      bx5_q     <= bx4_q;
      by5_q     <= by4_q;

      side6_q.touch  <= touch5_q;
      side6_q.pvalid <= pvalid5_q;
      side6_q.neg_x  <= px5_q[SCALE_BITS-1];
      side6_q.neg_y  <= py5_q[SCALE_BITS-1];
      side6_q.base_x <= bx5_q;
      side6_q.base_y <= by5_q;
      mx6_q  <= MAG_BITS'(ax_abs[ABS_BITS-1:0]) << FRAC_BITS;
      my6_q  <= MAG_BITS'(ay_abs[ABS_BITS-1:0]) << FRAC_BITS;
      den6_q <= pvalid5_q ? den5_q : DEN_BITS'(1);
    end
  end

  assign out_valid_o = v_q[5];
  assign side_o      = side6_q;
  assign mag_x_o     = mx6_q;
  assign mag_y_o     = my6_q;
  assign den_o       = den6_q;

endmodule

FILE: sv/spi_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes.
`timescale 1ns / 1ps
module spi_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  spi_pkg::div_side_t                side_i,
  input  logic [spi_pkg::MAG_BITS-1:0]      mag_x_i,
  input  logic [spi_pkg::MAG_BITS-1:0]      mag_y_i,
  input  logic [spi_pkg::DEN_BITS-1:0]      den_i,
  output logic                              out_valid_o,
  output spi_pkg::div_side_t                side_o,
  output logic [spi_pkg::QUO_BITS-1:0]      quo_x_o,
  output logic [spi_pkg::QUO_BITS-1:0]      quo_y_o,
  output logic [spi_pkg::DEN_BITS-1:0]      rem_x_o,
  output logic [spi_pkg::DEN_BITS-1:0]      rem_y_o,
  output logic [spi_pkg::DEN_BITS-1:0]      den_o
);
  import spi_pkg::*;

  logic [QUO_BITS-1:0] v_q;
  div_side_t           side_q [QUO_BITS];
  logic [DEN_BITS-1:0] den_q  [QUO_BITS];
  logic [DEN_BITS-1:0] rx_q   [QUO_BITS];
  logic [DEN_BITS-1:0] ry_q   [QUO_BITS];
  logic [QUO_BITS-1:0] lx_q   [QUO_BITS];
  logic [QUO_BITS-1:0] ly_q   [QUO_BITS];
  logic [QUO_BITS-1:0] qx_q   [QUO_BITS];
  logic [QUO_BITS-1:0] qy_q   [QUO_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QUO_BITS-2:0], in_valid_i};
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    div_side_t           side_in;
    logic [DEN_BITS-1:0] den_in, rx_in, ry_in;
    logic [QUO_BITS-1:0] lx_in, ly_in, qx_in, qy_in;
    logic [DEN_BITS:0]   tx, ty, dd;
    logic                gex, gey;

    if (k == 0) begin : g_first
      assign side_in = side_i;
      assign den_in  = den_i;
      assign rx_in   = mag_x_i[MAG_BITS-1:QUO_BITS];
      assign ry_in   = mag_y_i[MAG_BITS-1:QUO_BITS];
      assign lx_in   = mag_x_i[QUO_BITS-1:0];
      assign ly_in   = mag_y_i[QUO_BITS-1:0];
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_next
      assign side_in = side_q[k-1];
      assign den_in  = den_q[k-1];
      assign rx_in   = rx_q[k-1];
      assign ry_in   = ry_q[k-1];
      assign lx_in   = lx_q[k-1];
      assign ly_in   = ly_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
    end

    assign tx  = {rx_in, lx_in[QUO_BITS-1]};
    assign ty  = {ry_in, ly_in[QUO_BITS-1]};
    assign dd  = {1'b0, den_in};
    assign gex = (tx >= dd);
    assign gey = (ty >= dd);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        den_q[k]  <= den_in;
        rx_q[k]   <= gex ? DEN_BITS'(tx - dd) : tx[DEN_BITS-1:0];
        ry_q[k]   <= gey ? DEN_BITS'(ty - dd) : ty[DEN_BITS-1:0];
        lx_q[k]   <= lx_in << 1;
        ly_q[k]   <= ly_in << 1;
        qx_q[k]   <= {qx_in[QUO_BITS-2:0], gex};
        qy_q[k]   <= {qy_in[QUO_BITS-2:0], gey};
      end
    end
  end

  assign out_valid_o = v_q[QUO_BITS-1];
  assign side_o      = side_q[QUO_BITS-1];
  assign quo_x_o     = qx_q[QUO_BITS-1];
  assign quo_y_o     = qy_q[QUO_BITS-1];
  assign rem_x_o     = rx_q[QUO_BITS-1];
  assign rem_y_o     = ry_q[QUO_BITS-1];
  assign den_o       = den_q[QUO_BITS-1];

endmodule

FILE: sv/segment_pair_intersection_core.sv
// Top level of the segment pair intersection pipeline with output register.
`timescale 1ns / 1ps
// Tests two segments for contact and gives the crossing point on segment B,
// rounded to nearest with ties away from zero; cross_x and cross_y are zero
// unless point_valid. One transaction is taken per cycle while the output is
// not stalled; the pipeline runs through the geometry stages, the restoring
// divider, which resolves one quotient bit per stage, and the output register.
// All stages advance together, so a stall at the output holds the whole
// pipeline and in_ready_o follows out_ready_i while a result is waiting.
module segment_pair_intersection_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spi_pkg::spi_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spi_pkg::spi_out_t out_o
);
  import spi_pkg::*;

  logic                en;
  logic                g_valid, d_valid;
  div_side_t           g_side, d_side;
  logic [MAG_BITS-1:0] g_mx, g_my;
  logic [DEN_BITS-1:0] g_den, d_den, d_rx, d_ry;
  logic [QUO_BITS-1:0] d_qx, d_qy;

  logic                          up_x, up_y;
  logic [QUO_BITS:0]             qrx, qry;
  logic signed [OUT_BITS:0]      offx, offy, basex, basey, sumx, sumy;
  spi_out_t                      out_d, out_q;
  logic                          out_v_q;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  spi_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .out_valid_o (g_valid),
    .side_o      (g_side),
    .mag_x_o     (g_mx),
    .mag_y_o     (g_my),
    .den_o       (g_den)
  );

  spi_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (g_valid),
    .side_i      (g_side),
    .mag_x_i     (g_mx),
    .mag_y_i     (g_my),
    .den_i       (g_den),
    .out_valid_o (d_valid),
    .side_o      (d_side),
    .quo_x_o     (d_qx),
    .quo_y_o     (d_qy),
    .rem_x_o     (d_rx),
    .rem_y_o     (d_ry),
    .den_o       (d_den)
  );

  assign up_x  = ({d_rx, 1'b0} >= {1'b0, d_den});
  assign up_y  = ({d_ry, 1'b0} >= {1'b0, d_den});
  assign qrx   = (QUO_BITS + 1)'(d_qx) + (QUO_BITS + 1)'(up_x);
  assign qry   = (QUO_BITS + 1)'(d_qy) + (QUO_BITS + 1)'(up_y);
  assign offx  = d_side.neg_x ? -signed'(qrx) : signed'(qrx);
  assign offy  = d_side.neg_y ? -signed'(qry) : signed'(qry);
  assign basex = (OUT_BITS + 1)'(d_side.base_x) <<< FRAC_BITS;
  assign basey = (OUT_BITS + 1)'(d_side.base_y) <<< FRAC_BITS;
  assign sumx  = basex + offx;
  assign sumy  = basey + offy;

  always_comb begin
    out_d.segments_touch = d_side.touch;
    out_d.point_valid    = d_side.pvalid;
    out_d.cross_x        = d_side.pvalid ? sumx[OUT_BITS-1:0] : '0;
    out_d.cross_y        = d_side.pvalid ? sumy[OUT_BITS-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_valid_needs_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.point_valid |-> out_o.segments_touch)
    else $error("point_valid without segments_touch");

  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.point_valid |-> (out_o.cross_x == '0) && (out_o.cross_y == '0))
    else $error("crossing point not zero when invalid");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");
`endif

endmodule
